@@ design/cnpb_pkg.sv @@
// Shared types and constants for the CAN NMT / PDO to panel bus block.
// No dependencies.
package cnpb_pkg;

    localparam int FRAME_ID_W  = 29;
    localparam int NODE_ID_W   = 7;
    localparam int PDO_ID_W    = 11;
    localparam int LEN_W       = 4;
    localparam int WORD_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;
    localparam int JOB_BYTES   = 7;
    localparam int CNT_W       = 3;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [LEN_W-1:0]  NMT_MIN_LEN     = 4'd2;
    localparam logic [CNT_W-1:0]  MAX_PARAM_BYTES = 3'd6;
    localparam logic [PDO_ID_W-1:0] RX_PDO_ID_RST = 11'd512;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_ID   = 1'b0,
        CFG_RX_PDO_ID = 1'b1
    } t_cfg_idx;

    typedef enum logic [BYTE_W-1:0] {
        NMT_RUN   = 8'h01,
        NMT_HALT  = 8'h02,
        NMT_PREOP = 8'h80
    } t_nmt_cmd;

    typedef enum logic [2:0] {
        ST_OPER  = 3'b001,
        ST_PREOP = 3'b010,
        ST_STOP  = 3'b100
    } t_node_state;

    // Display request: command byte in slot 0, parameter bytes after it.
    typedef struct packed {
        logic [CNT_W-1:0]                 count;
        logic [JOB_BYTES-1:0][BYTE_W-1:0] bytes;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

@@ design/cnpb_front.sv @@
// Front end: configuration registers, node state, frame classification.
// Depends on cnpb_pkg.
module cnpb_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [cnpb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cnpb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_accept,
    input  logic [cnpb_pkg::FRAME_ID_W-1:0] i_frame_id,
    input  logic                            i_is_remote,
    input  logic [cnpb_pkg::LEN_W-1:0]      i_data_length,
    input  logic [cnpb_pkg::WORD_W-1:0]     i_payload_low,
    input  logic [cnpb_pkg::WORD_W-1:0]     i_payload_high,
    output logic                            o_job_push,
    output cnpb_pkg::t_job                  o_job
);
    import cnpb_pkg::*;

    logic [NODE_ID_W-1:0] r_node_id, n_node_id;
    logic [PDO_ID_W-1:0]  r_rx_pdo_id, n_rx_pdo_id;
    t_node_state          r_state, n_state;

    logic [BYTE_W-1:0] w_b0, w_b1;
    logic              w_data_frame, w_is_nmt, w_nmt_hit, w_pdo_hit;

    assign w_b0 = i_payload_low[7:0];
    assign w_b1 = i_payload_low[15:8];
    assign w_data_frame = !i_is_remote && (i_data_length != '0);
    assign w_is_nmt     = (i_frame_id == '0);
    assign w_nmt_hit    = i_accept && w_data_frame && w_is_nmt
                          && (i_data_length >= NMT_MIN_LEN)
                          && ((w_b0 == '0) || (w_b0 == {1'b0, r_node_id}));
    assign w_pdo_hit    = i_accept && w_data_frame && !w_is_nmt
                          && (i_frame_id == FRAME_ID_W'(r_rx_pdo_id))
                          && (r_state == ST_OPER)
                          && (w_b0 <= BYTE_W'(MAX_PARAM_BYTES));

    assign o_job_push  = w_pdo_hit;
    assign o_job.count = w_b0[CNT_W-1:0];
    assign o_job.bytes = {i_payload_high, i_payload_low[31:8]};

    always_comb begin
        n_node_id   = r_node_id;
        n_rx_pdo_id = r_rx_pdo_id;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_NODE_ID:   n_node_id   = i_cfg_data[NODE_ID_W-1:0];
                CFG_RX_PDO_ID: n_rx_pdo_id = i_cfg_data[PDO_ID_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        if (w_nmt_hit) begin
            unique case (w_b1)
                NMT_RUN:   n_state = ST_OPER;
                NMT_PREOP: n_state = ST_PREOP;
                NMT_HALT:  n_state = ST_STOP;
                default:   n_state = r_state;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id   <= '0;
            r_rx_pdo_id <= RX_PDO_ID_RST;
            r_state     <= ST_OPER;
        end else begin
            r_node_id   <= n_node_id;
            r_rx_pdo_id <= n_rx_pdo_id;
            r_state     <= n_state;
        end
    end

endmodule

@@ design/cnpb_queue.sv @@
// Short request queue between front end and bus sequencer.
// Depends on cnpb_pkg.
module cnpb_queue #(
    parameter int DEPTH = cnpb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  cnpb_pkg::t_job       i_job,
    input  logic                 i_pop,
    output cnpb_pkg::t_job       o_job,
    output cnpb_pkg::t_q_status  o_status
);
    import cnpb_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [OCC_W-1:0] r_occ, n_occ;
    logic             w_push, w_pop;

    assign o_status.full  = (r_occ == OCC_W'(DEPTH));
    assign o_status.empty = (r_occ == '0);
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_job  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_occ = r_occ;
        if (w_push) n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        if (w_pop)  n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        if (w_push && !w_pop)      n_occ = r_occ + 1'b1;
        else if (w_pop && !w_push) n_occ = r_occ - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_occ <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_job;
    end

endmodule

@@ design/cnpb_back.sv @@
// Bus sequencer: walks the head request byte by byte into an output register.
// Depends on cnpb_pkg.
module cnpb_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cnpb_pkg::t_job                i_job,
    input  logic                          i_job_valid,
    output logic                          o_job_pop,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic                          o_is_data_byte,
    output logic [cnpb_pkg::BYTE_W-1:0]   o_bus_byte,
    output logic                          o_last
);
    import cnpb_pkg::*;

    logic [CNT_W-1:0]  r_k, n_k;
    logic              r_out_valid, n_out_valid;
    logic              r_out_data, r_out_last;
    logic [BYTE_W-1:0] r_out_byte;
    logic              w_load, w_end;

    assign w_load    = i_job_valid && (!r_out_valid || i_pop);
    assign w_end     = (r_k == i_job.count);
    assign o_job_pop = w_load && w_end;

    always_comb begin
        n_k         = r_k;
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
            n_k         = w_end ? '0 : r_k + 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_byte <= i_job.bytes[r_k];
            r_out_data <= (r_k != '0);
            r_out_last <= w_end;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_is_data_byte = r_out_data;
    assign o_bus_byte     = r_out_byte;
    assign o_last         = r_out_last;

endmodule

@@ design/can_nmt_pdo_to_panel_bus_top.sv @@
// Top level: CAN NMT / display PDO receiver driving a panel byte bus.
// Depends on cnpb_pkg, cnpb_front, cnpb_queue, cnpb_back.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------------
//  frame in | i_push / o_full         | i_frame_id i_is_remote i_data_length i_payload_*
//  bytes out| o_empty / i_pop         | o_is_data_byte o_bus_byte o_last
//  config   | i_cfg_valid/o_cfg_ready | i_cfg_index i_cfg_data
//
// A frame is classified in its accept cycle; NMT commands update node state there.
// A display request with count n gives n+1 bytes, one per cycle while the receiver pops.
// Frames are taken every cycle while the request queue has room; the first byte is
// registered in the queue, then in the output register. Reset is synchronous; node
// state returns to operational, node_id to 0, rx_pdo_id to 512. Config is always ready.
module can_nmt_pdo_to_panel_bus_top #(
    parameter int QUEUE_DEPTH = cnpb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    output logic                            o_full,
    input  logic [cnpb_pkg::FRAME_ID_W-1:0] i_frame_id,
    input  logic                            i_is_remote,
    input  logic [cnpb_pkg::LEN_W-1:0]      i_data_length,
    input  logic [cnpb_pkg::WORD_W-1:0]     i_payload_low,
    input  logic [cnpb_pkg::WORD_W-1:0]     i_payload_high,
    output logic                            o_empty,
    input  logic                            i_pop,
    output logic                            o_is_data_byte,
    output logic [cnpb_pkg::BYTE_W-1:0]     o_bus_byte,
    output logic                            o_last,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cnpb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cnpb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cnpb_pkg::*;

    t_job      w_in_job, w_head_job;
    t_q_status w_q;
    logic      w_accept, w_job_push, w_job_pop;

    assign o_cfg_ready = 1'b1;
    assign o_full      = w_q.full;
    assign w_accept    = i_push && !w_q.full;

    cnpb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (w_accept),
        .i_frame_id     (i_frame_id),
        .i_is_remote    (i_is_remote),
        .i_data_length  (i_data_length),
        .i_payload_low  (i_payload_low),
        .i_payload_high (i_payload_high),
        .o_job_push     (w_job_push),
        .o_job          (w_in_job)
    );

    cnpb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_job_push),
        .i_job    (w_in_job),
        .i_pop    (w_job_pop),
        .o_job    (w_head_job),
        .o_status (w_q)
    );

    cnpb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (w_head_job),
        .i_job_valid    (!w_q.empty),
        .o_job_pop      (w_job_pop),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_is_data_byte (o_is_data_byte),
        .o_bus_byte     (o_bus_byte),
        .o_last         (o_last)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_job_push && w_q.full))
        else $error("request pushed into full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_pop |-> !w_q.empty)
        else $error("request popped from empty queue");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("result present right after reset");

    a_command_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && o_last) |=> (o_empty || !o_is_data_byte))
        else $error("run does not start with a command byte");

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for can_nmt_pdo_to_panel_bus_top: CAN frame requests in,
// panel bus bytes out, register writes between phases.
// Depends on cnpb_pkg and the RTL; a scoreboard class predicts node state and bytes.
module tb_top;
    import cnpb_pkg::*;

    typedef struct {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last;
    } t_bus_beat;

    class panel_bus_scoreboard;
        bit [NODE_ID_W-1:0] node_id;
        bit [PDO_ID_W-1:0]  rx_pdo_id;
        t_node_state        node_state;
        t_bus_beat          pending[$];
        int                 errors;
        int                 frames;
        int                 runs;
        int                 beats;
        int                 reg_writes;

        function new();
            node_id    = '0;
            rx_pdo_id  = RX_PDO_ID_RST;
            node_state = ST_OPER;
            errors     = 0;
            frames     = 0;
            runs       = 0;
            beats      = 0;
            reg_writes = 0;
        endfunction

        function void note_cfg(t_cfg_idx idx, bit [CFG_DATA_W-1:0] data);
            reg_writes++;
            if (idx == CFG_NODE_ID) begin
                node_id = data[NODE_ID_W-1:0];
            end else begin
                rx_pdo_id = data[PDO_ID_W-1:0];
            end
        endfunction

        function void note_frame(bit [FRAME_ID_W-1:0] fid, bit remote, bit [LEN_W-1:0] len,
                                 bit [WORD_W-1:0] lo, bit [WORD_W-1:0] hi);
            bit [2*WORD_W-1:0] data;
            bit [BYTE_W-1:0]   count;
            t_bus_beat         beat;
            data  = {hi, lo};
            count = lo[7:0];
            frames++;
            if (remote || len == 0) return;
            if (fid == 0) begin
                if (len >= NMT_MIN_LEN && (count == 0 || count == {1'b0, node_id})) begin
                    case (lo[15:8])
                        NMT_RUN:   node_state = ST_OPER;
                        NMT_HALT:  node_state = ST_STOP;
                        NMT_PREOP: node_state = ST_PREOP;
                        default: ;
                    endcase
                end
                return;
            end
            if (fid != FRAME_ID_W'(rx_pdo_id) || node_state != ST_OPER) return;
            if (count > MAX_PARAM_BYTES) return;
            runs++;
            for (int k = 0; k <= count; k++) begin
                beat.is_data  = (k != 0);
                beat.bus_byte = data[(k+1)*8 +: 8];
                beat.last     = (k == count);
                pending.push_back(beat);
            end
        endfunction

        function void check_beat(logic is_data, logic [BYTE_W-1:0] bus_byte, logic last);
            t_bus_beat exp_beat;
            beats++;
            if (pending.size() == 0) begin
                $error("unexpected bus byte %02h", bus_byte);
                errors++;
                return;
            end
            exp_beat = pending.pop_front();
            if (is_data !== exp_beat.is_data) begin
                $error("is_data_byte: expected %0d, got %0d", exp_beat.is_data, is_data);
                errors++;
            end
            if (bus_byte !== exp_beat.bus_byte) begin
                $error("bus_byte: expected %02h, got %02h", exp_beat.bus_byte, bus_byte);
                errors++;
            end
            if (last !== exp_beat.last) begin
                $error("last: expected %0d, got %0d", exp_beat.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_push         = 1'b0;
    logic                    o_full;
    logic [FRAME_ID_W-1:0]   i_frame_id     = '0;
    logic                    i_is_remote    = 1'b0;
    logic [LEN_W-1:0]        i_data_length  = '0;
    logic [WORD_W-1:0]       i_payload_low  = '0;
    logic [WORD_W-1:0]       i_payload_high = '0;
    logic                    o_empty;
    logic                    i_pop          = 1'b0;
    logic                    o_is_data_byte;
    logic [BYTE_W-1:0]       o_bus_byte;
    logic                    o_last;
    logic                    i_cfg_valid    = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data     = '0;

    panel_bus_scoreboard sb;
    int sender_idle_pct = 0;
    int rx_stall_pct    = 0;
    int hold_left       = 0;

    can_nmt_pdo_to_panel_bus_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_frame_id     (i_frame_id),
        .i_is_remote    (i_is_remote),
        .i_data_length  (i_data_length),
        .i_payload_low  (i_payload_low),
        .i_payload_high (i_payload_high),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_is_data_byte (o_is_data_byte),
        .o_bus_byte     (o_bus_byte),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_push && !o_full) begin
                sb.note_frame(i_frame_id, i_is_remote, i_data_length,
                              i_payload_low, i_payload_high);
            end
            if (i_pop && !o_empty) begin
                sb.check_beat(o_is_data_byte, o_bus_byte, o_last);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.note_cfg(t_cfg_idx'(i_cfg_index), i_cfg_data);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_pop <= 1'b0;
            end else begin
                i_pop <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial begin
        #400000;
        $display("FAIL");
        $finish;
    end

    task automatic send_frame(input bit [FRAME_ID_W-1:0] fid, input bit remote,
                              input bit [LEN_W-1:0] len, input bit [WORD_W-1:0] lo,
                              input bit [WORD_W-1:0] hi);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push         <= 1'b1;
        i_frame_id     <= fid;
        i_is_remote    <= remote;
        i_data_length  <= len;
        i_payload_low  <= lo;
        i_payload_high <= hi;
        do @(posedge i_clk); while (o_full);
    endtask

    task automatic send_random_frame(output bit counted);
        int unsigned         pick;
        bit [FRAME_ID_W-1:0] fid;
        bit                  remote;
        bit [LEN_W-1:0]      len;
        bit [WORD_W-1:0]     lo;
        bit [WORD_W-1:0]     hi;
        pick    = $urandom_range(99);
        lo      = $urandom();
        hi      = $urandom();
        remote  = 1'b0;
        counted = 1'b1;
        if (pick < 60) begin
            fid = FRAME_ID_W'(sb.rx_pdo_id);
            len = ($urandom_range(3) == 0) ? LEN_W'($urandom_range(1, 15)) : LEN_W'(8);
            lo[7:0] = ($urandom_range(9) == 0) ? 8'($urandom_range(7, 255))
                                               : 8'($urandom_range(0, 6));
        end else if (pick < 82) begin
            fid = '0;
            len = ($urandom_range(7) == 0) ? LEN_W'($urandom_range(0, 1))
                                           : LEN_W'($urandom_range(2, 15));
            counted = (len >= NMT_MIN_LEN);
            case ($urandom_range(3))
                0: lo[7:0] = 8'h00;
                1: lo[7:0] = {1'b0, sb.node_id};
                2: lo[7:0] = {1'b1, sb.node_id};
                default: ;
            endcase
            case ($urandom_range(9))
                0, 1, 2, 3, 4: lo[15:8] = NMT_RUN;
                5, 6:          lo[15:8] = NMT_HALT;
                7, 8:          lo[15:8] = NMT_PREOP;
                default: ;
            endcase
        end else if (pick < 90) begin
            fid     = FRAME_ID_W'(sb.rx_pdo_id);
            remote  = 1'($urandom_range(1));
            len     = remote ? LEN_W'($urandom_range(15)) : LEN_W'(0);
            lo[7:0] = 8'($urandom_range(0, 6));
            counted = 1'b0;
        end else begin
            fid     = FRAME_ID_W'($urandom());
            remote  = 1'($urandom_range(1));
            len     = LEN_W'($urandom_range(15));
            counted = 1'b0;
        end
        send_frame(fid, remote, len, lo, hi);
    endtask

    task automatic wait_drained(input int limit);
        int n;
        n = 0;
        i_push <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0 && n < limit) begin
            @(posedge i_clk);
            n++;
        end
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_regs(input bit [CFG_DATA_W-1:0] node_word,
                            input bit [CFG_DATA_W-1:0] pdo_word);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_NODE_ID;
        i_cfg_data  <= node_word;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_RX_PDO_ID;
        i_cfg_data  <= pdo_word;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        bit [FRAME_ID_W-1:0] pdo_fid;
        bit                  hit;
        int                  counted;
        int                  idle_tbl[4];
        int                  stall_tbl[4];
        idle_tbl  = '{0, 56, 0, 23};
        stall_tbl = '{0, 0, 56, 23};
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset registers, node 0, display id 512.
        pdo_fid = FRAME_ID_W'(RX_PDO_ID_RST);
        send_frame(pdo_fid, 1'b0, 4'd8, 32'h3322_1100, 32'h7766_5544);
        send_frame(pdo_fid, 1'b0, 4'd8, 32'hFFFF_FF06, 32'hFFFF_FFFF);
        send_frame(pdo_fid, 1'b0, 4'd8, 32'h0000_0006, 32'h0000_0000);
        send_frame(pdo_fid, 1'b0, 4'd1, 32'hA5C3_5A03, 32'h0F1E_2D3C);
        send_frame(pdo_fid, 1'b0, 4'd15, 32'h1234_5602, 32'h89AB_CDEF);
        send_frame(pdo_fid, 1'b0, 4'd8, 32'h0102_0307, 32'h0405_0607);
        send_frame(pdo_fid, 1'b0, 4'd8, 32'h0102_03FF, 32'h0405_0607);
        send_frame(pdo_fid, 1'b1, 4'd8, 32'h0102_0304, 32'h0405_0607);
        send_frame(pdo_fid, 1'b0, 4'd0, 32'h0102_0304, 32'h0405_0607);
        send_frame(pdo_fid | 29'h800, 1'b0, 4'd8, 32'h0102_0302, 32'h0);
        send_frame(pdo_fid | 29'h1000_0000, 1'b0, 4'd8, 32'h0102_0302, 32'h0);
        send_frame(29'h1FFF_FFFF, 1'b0, 4'd8, 32'hDEAD_BE02, 32'hCAFE_F00D);
        send_frame('0, 1'b0, 4'd2, {16'h0, NMT_HALT, 8'h00}, 32'h0);
        send_frame(pdo_fid, 1'b0, 4'd8, 32'h0000_5501, 32'h0);
        send_frame('0, 1'b0, 4'd8, 32'h0000_8100, 32'h0);
        send_frame(pdo_fid, 1'b0, 4'd8, 32'h0000_5501, 32'h0);
        send_frame('0, 1'b0, 4'd1, {16'h0, NMT_RUN, 8'h00}, 32'h0);
        send_frame('0, 1'b0, 4'd2, {16'h0, NMT_RUN, 8'h80}, 32'h0);
        send_frame('0, 1'b1, 4'd2, {16'h0, NMT_RUN, 8'h00}, 32'h0);
        send_frame(pdo_fid, 1'b0, 4'd8, 32'h0000_5501, 32'h0);
        send_frame('0, 1'b0, 4'd15, {16'hFFFF, NMT_PREOP, 8'h00}, 32'hFFFF_FFFF);
        send_frame(pdo_fid, 1'b0, 4'd8, 32'h0000_5501, 32'h0);
        send_frame('0, 1'b0, 4'd2, {16'h0, NMT_RUN, 8'h00}, 32'h0);
        send_frame(pdo_fid, 1'b0, 4'd8, 32'h4433_2204, 32'h8877_6655);
        wait_drained(20000);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: set_regs({4'($urandom_range(15)), 7'h7F}, 11'h7FF);
                1: set_regs(11'($urandom()), 11'h000);
                2: set_regs({4'($urandom_range(15)), 7'h00}, 11'($urandom()));
                default: set_regs(11'($urandom()), 11'($urandom()));
            endcase
            sender_idle_pct = idle_tbl[p];
            rx_stall_pct    = stall_tbl[p];
            counted = 0;
            while (counted < 21) begin
                send_random_frame(hit);
                counted += hit;
            end
            wait_drained(20000);
        end

        // Back-pressure: receiver holds off while full-length requests keep coming.
        sender_idle_pct = 0;
        rx_stall_pct    = 0;
        send_frame('0, 1'b0, 4'd2, {16'h0, NMT_RUN, 8'h00}, 32'h0);
        hold_left = 300;
        for (int n = 0; n < 20; n++) begin
            send_frame(FRAME_ID_W'(sb.rx_pdo_id), 1'b0, 4'd8,
                       {24'($urandom()), 8'd6}, $urandom());
        end
        wait_drained(20000);

        if (sb.pending.size() != 0) begin
            $error("%0d bus bytes never arrived", sb.pending.size());
            sb.errors++;
        end
        $display("Ran %0d frames, %0d display runs, %0d bus bytes checked, %0d register writes.",
                 sb.frames, sb.runs, sb.beats, sb.reg_writes);
        $display("Phases: directed, four register settings with idle/stall mixes, back-pressure.");
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

@@ sim.f @@
design/cnpb_pkg.sv
design/cnpb_front.sv
design/cnpb_queue.sv
design/cnpb_back.sv
design/can_nmt_pdo_to_panel_bus_top.sv
tb/sv/tb_top.sv
